// ===== rtl/m2cv_pkg.sv =====
// Shared types, constants and DAC word helpers for the MIDI event to CV frame block.
// Used by m2cv_slots and midi_event_to_cv_dac_frames; depends on nothing else.
`timescale 1ns / 1ps

package m2cv_pkg;

  localparam int unsigned SLOT_COUNT = 3;
  localparam int unsigned SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [3:0]  CMD_NOTE_OFF = 4'h8;
  localparam logic [3:0]  CMD_NOTE_ON  = 4'h9;
  localparam logic [3:0]  CMD_CTRL     = 4'hB;

  localparam logic [7:0]  SX_VOICE_CHAN = 8'h10;
  localparam logic [7:0]  SX_CTRL_CHAN  = 8'h20;
  localparam logic [7:0]  SX_CTRL_NUM   = 8'h30;

  localparam logic [7:0]  NO_NOTE  = 8'hFF;
  localparam logic [7:0]  DAC_HDR  = 8'h30;
  localparam logic [11:0] PITCH_ON = 12'hFFF;

  localparam logic        KIND_DAC  = 1'b0;
  localparam logic        KIND_GATE = 1'b1;

  typedef enum logic [1:0] {
    REC_NONE,
    REC_VOICE,
    REC_CTRL
  } rec_kind_e;

  typedef enum logic [1:0] {
    STEP_GATE,
    STEP_LEVEL,
    STEP_PITCH
  } step_e;

  typedef struct packed {
    rec_kind_e         kind;
    logic [SLOT_W-1:0] slot;
    logic              gate_on;
    logic [7:0]        level;
  } event_rec_t;

  function automatic logic [15:0] word8(input logic [7:0] v, input logic sub);
    logic [7:0] hi;
    hi = DAC_HDR | {sub, 3'b000, v[7:4]};
    return {hi, v[3:0], 4'b0000};
  endfunction

  function automatic logic [15:0] word12(input logic [11:0] p);
    return {DAC_HDR | {4'b0000, p[11:8]}, p[7:0]};
  endfunction

  function automatic logic [7:0] level_sel(input logic [SLOT_W-1:0] s);
    logic [7:0] m;
    case (32'(s))
      0:       m = 8'h10;
      1:       m = 8'h02;
      2:       m = 8'h01;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] pitch_sel(input logic [SLOT_W-1:0] s);
    logic [7:0] m;
    case (32'(s))
      0:       m = 8'h80;
      1:       m = 8'h40;
      2:       m = 8'h20;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/m2cv_slots.sv =====
// Voice and controller slot state with the event decoder that reads and updates it.
// Depends on m2cv_pkg.
`timescale 1ns / 1ps

module m2cv_slots
  import m2cv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] status_i,
  input  logic [7:0] first_i,
  input  logic [7:0] second_i,
  input  logic       sysex_i,
  output event_rec_t rec_o
);

  logic [7:0] voice_chan_q [SLOT_COUNT];
  logic [7:0] held_note_q  [SLOT_COUNT];
  logic [7:0] ctrl_chan_q  [SLOT_COUNT];
  logic [7:0] ctrl_num_q   [SLOT_COUNT];

  logic [3:0]        cmd;
  logic [7:0]        chan;
  logic              on_hit, off_hit, cc_hit;
  logic [SLOT_W-1:0] on_idx, off_idx, cc_idx;
  logic              held_we;
  logic [SLOT_W-1:0] held_idx;
  logic [7:0]        held_val;
  logic              sx_ok;
  logic [SLOT_W-1:0] sx_idx;

  assign cmd    = status_i[7:4];
  assign chan   = {4'h0, status_i[3:0]};
  assign sx_ok  = first_i < 8'(SLOT_COUNT);
  assign sx_idx = first_i[SLOT_W-1:0];

  always_comb begin
    on_hit  = 1'b0;
    off_hit = 1'b0;
    cc_hit  = 1'b0;
    on_idx  = '0;
    off_idx = '0;
    cc_idx  = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (voice_chan_q[i] == chan) begin
        on_hit = 1'b1;
        on_idx = SLOT_W'(i);
      end
      if (voice_chan_q[i] == chan && held_note_q[i] != NO_NOTE &&
          held_note_q[i] == first_i) begin
        off_hit = 1'b1;
        off_idx = SLOT_W'(i);
      end
      if (ctrl_chan_q[i] == chan && ctrl_num_q[i] == first_i) begin
        cc_hit = 1'b1;
        cc_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    rec_o    = '{kind: REC_NONE, slot: '0, gate_on: 1'b0, level: 8'h00};
    held_we  = 1'b0;
    held_idx = off_idx;
    held_val = NO_NOTE;
    if (cmd == CMD_NOTE_ON && second_i != 8'h00) begin
      if (on_hit) begin
        rec_o    = '{kind: REC_VOICE, slot: on_idx, gate_on: 1'b1,
                     level: {second_i[6:0], 1'b0}};
        held_we  = 1'b1;
        held_idx = on_idx;
        held_val = first_i;
      end
    end else if ((cmd == CMD_NOTE_ON) || (cmd != CMD_CTRL && !sysex_i &&
                 cmd == CMD_NOTE_OFF)) begin
      if (off_hit) begin
        rec_o   = '{kind: REC_VOICE, slot: off_idx, gate_on: 1'b0, level: 8'h00};
        held_we = 1'b1;
      end
    end else if (cmd == CMD_CTRL) begin
      if (cc_hit) begin
        rec_o = '{kind: REC_CTRL, slot: cc_idx, gate_on: 1'b0,
                  level: {second_i[6:0], 1'b0}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        voice_chan_q[i] <= 8'(i);
        held_note_q[i]  <= NO_NOTE;
        ctrl_chan_q[i]  <= 8'h00;
        ctrl_num_q[i]   <= 8'(i);
      end
    end else if (accept_i) begin
      if (held_we) begin
        held_note_q[held_idx] <= held_val;
      end
      if (sysex_i && cmd != CMD_NOTE_ON && cmd != CMD_CTRL && sx_ok) begin
        case (status_i)
          SX_VOICE_CHAN: voice_chan_q[sx_idx] <= second_i;
          SX_CTRL_CHAN:  ctrl_chan_q[sx_idx]  <= second_i;
          SX_CTRL_NUM:   ctrl_num_q[sx_idx]   <= second_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/midi_event_to_cv_dac_frames.sv =====
// Top level: MIDI event stream in, gate changes and DAC SPI words out.
// Depends on m2cv_pkg and m2cv_slots.
//
// The input channel takes one MIDI event per word: status, first and second
// data byte in tdata, and the sysex flag in tuser. Slot state is read and
// updated in the cycle the event is accepted, and the decoded event waits in
// one pending register. The output channel then gives one word per cycle,
// while the receiver is ready, from a registered output stage: a note event
// gives a gate word, a level DAC word and a pitch DAC word; a control change
// gives one level DAC word; unmatched events and sysex events without a
// note-on or control-change status give nothing. tlast marks the final word
// of an event. The pending event is held until its last word issues. A new
// event is accepted in the cycle the pending event issues its last word, or
// when nothing is pending. When the receiver stalls, the output word holds
// and the pending event waits, and input is refused once the pending
// register is occupied. Reset restores the slot mapping (voice channels 0,
// 1, 2, no held notes, controller channel 0 with numbers 0, 1, 2) and
// empties both stages.
`timescale 1ns / 1ps

module midi_event_to_cv_dac_frames
  import m2cv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // status_byte [7:0], first_data [15:8], second_data [23:16]
  input  logic [23:0] s_axis_tdata_i,
  // is_sysex [0]
  input  logic [0:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // select_mask [7:0], dac_word [23:8], gate_index [25:24], gate_level [26], zero [31:27]
  output logic [31:0] m_axis_tdata_o,
  // frame_kind [0]
  output logic [0:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  event_rec_t dec_rec;
  event_rec_t pend_q, pend_d;
  step_e      step_q, step_d;
  logic       accept, busy, out_adv, word_last, pend_done;
  logic       out_valid_q;
  logic       kind_d, kind_q, last_d, last_q, gl_d, gl_q;
  logic [7:0] sel_d, sel_q;
  logic [15:0] word_d, word_q;
  logic [1:0] gi_d, gi_q;

  m2cv_slots u_slots (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .status_i (s_axis_tdata_i[7:0]),
    .first_i  (s_axis_tdata_i[15:8]),
    .second_i (s_axis_tdata_i[23:16]),
    .sysex_i  (s_axis_tuser_i[0]),
    .rec_o    (dec_rec)
  );

  assign busy      = pend_q.kind != REC_NONE;
  assign out_adv   = !out_valid_q || m_axis_tready_i;
  assign word_last = (pend_q.kind == REC_CTRL) || (step_q == STEP_PITCH);
  assign pend_done = out_adv && busy && word_last;
  assign s_axis_tready_o = !busy || pend_done;
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    pend_d = pend_q;
    step_d = step_q;
    if (out_adv && busy) begin
      case (step_q)
        STEP_GATE:  step_d = STEP_LEVEL;
        STEP_LEVEL: step_d = STEP_PITCH;
        default:    step_d = STEP_GATE;
      endcase
      if (word_last) begin
        step_d = STEP_GATE;
      end
    end
    if (accept) begin
      pend_d = dec_rec;
      step_d = (dec_rec.kind == REC_CTRL) ? STEP_LEVEL : STEP_GATE;
    end else if (pend_done) begin
      pend_d.kind = REC_NONE;
    end
  end

  always_comb begin
    kind_d = KIND_DAC;
    sel_d  = 8'h00;
    word_d = 16'h0000;
    gi_d   = 2'b00;
    gl_d   = 1'b0;
    last_d = word_last;
    case (step_q)
      STEP_GATE: begin
        kind_d = KIND_GATE;
        gi_d   = 2'(pend_q.slot);
        gl_d   = pend_q.gate_on;
      end
      STEP_LEVEL: begin
        sel_d  = level_sel(pend_q.slot);
        word_d = word8(pend_q.level, pend_q.kind == REC_CTRL);
      end
      default: begin
        sel_d  = pitch_sel(pend_q.slot);
        word_d = word12(pend_q.gate_on ? PITCH_ON : 12'h000);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '{kind: REC_NONE, slot: '0, gate_on: 1'b0, level: 8'h00};
      step_q      <= STEP_GATE;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      step_q <= step_d;
      if (out_adv) begin
        out_valid_q <= busy;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && busy) begin
      kind_q <= kind_d;
      sel_q  <= sel_d;
      word_q <= word_d;
      gi_q   <= gi_d;
      gl_q   <= gl_d;
      last_q <= last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b00000, gl_q, gi_q, word_q, sel_q};
  assign m_axis_tuser_o  = kind_q;
  assign m_axis_tlast_o  = last_q;

endmodule

// ===== verif/midi_event_to_cv_dac_frames_tb.sv =====
// Self-checking testbench for midi_event_to_cv_dac_frames: MIDI events in, gate and DAC words out.
// It runs a directed event table and then random event streams, and checks every output word
// against the table or an in-bench slot model. It depends on m2cv_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module midi_event_to_cv_dac_frames_tb;
  import m2cv_pkg::*;

  typedef struct packed {
    logic [7:0] status;
    logic [7:0] d1;
    logic [7:0] d2;
    logic       sx;
  } midi_ev_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  cs;
    logic [15:0] word;
    logic [1:0]  gidx;
    logic        glvl;
    logic        last;
  } cv_frame_t;

  typedef struct packed {
    midi_ev_t             ev;
    logic                 typed;
    logic [1:0]           n;
    cv_frame_t [2:0]      exp;
  } dir_row_t;

  localparam logic [2:0][7:0] LVL_CS = {8'h01, 8'h02, 8'h10};
  localparam logic [2:0][7:0] PIT_CS = {8'h20, 8'h40, 8'h80};
  localparam int RAND_PER_PHASE = 85;

  logic        clk_i;
  logic        rst_n;
  logic        ev_tvalid;
  logic        ev_tready;
  logic [23:0] ev_tdata;
  logic [0:0]  ev_tuser;
  logic        fr_tvalid;
  logic        fr_tready;
  logic [31:0] fr_tdata;
  logic [0:0]  fr_tuser;
  logic        fr_tlast;

  logic [7:0]  vc_chan [SLOT_COUNT];
  logic [7:0]  vc_note [SLOT_COUNT];
  logic [7:0]  cc_chan [SLOT_COUNT];
  logic [7:0]  cc_num  [SLOT_COUNT];

  cv_frame_t   frames_due [$];
  dir_row_t    dir_tab [$];

  int n_errors     = 0;
  int n_events     = 0;
  int n_gate_words = 0;
  int n_dac_words  = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_left    = 0;
  bit hold_req     = 1'b0;

  midi_event_to_cv_dac_frames u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (ev_tvalid),
    .s_axis_tready_o (ev_tready),
    .s_axis_tdata_i  (ev_tdata),
    .s_axis_tuser_i  (ev_tuser),
    .m_axis_tvalid_o (fr_tvalid),
    .m_axis_tready_i (fr_tready),
    .m_axis_tdata_o  (fr_tdata),
    .m_axis_tuser_o  (fr_tuser),
    .m_axis_tlast_o  (fr_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic cv_frame_t frm(logic k, logic [7:0] cs, logic [15:0] w, logic [1:0] gi,
                                    logic gl, logic lst);
    cv_frame_t f;
    f = '{kind: k, cs: cs, word: w, gidx: gi, glvl: gl, last: lst};
    return f;
  endfunction

  function automatic dir_row_t row(logic [7:0] st, logic [7:0] a, logic [7:0] b, logic sx,
                                   logic typed, logic [1:0] n, cv_frame_t f0, cv_frame_t f1,
                                   cv_frame_t f2);
    dir_row_t r;
    r.ev    = '{status: st, d1: a, d2: b, sx: sx};
    r.typed = typed;
    r.n     = n;
    r.exp   = {f2, f1, f0};
    return r;
  endfunction

  function automatic logic [15:0] level_word(logic [7:0] v, logic sub);
    return {sub, DAC_HDR[6:4], v, 4'h0};
  endfunction

  function automatic cv_frame_t [2:0] voice_words(int slot, logic on, logic [7:0] lvl);
    cv_frame_t [2:0] f;
    f = '0;
    f[0] = frm(KIND_GATE, 8'h00, 16'h0000, 2'(slot), on, 1'b0);
    f[1] = frm(KIND_DAC, LVL_CS[slot], level_word(lvl, 1'b0), 2'd0, 1'b0, 1'b0);
    f[2] = frm(KIND_DAC, PIT_CS[slot], {DAC_HDR[7:4], on ? PITCH_ON : 12'h000}, 2'd0, 1'b0,
               1'b1);
    return f;
  endfunction

  // Applies one event to the slot state and returns the words it should produce.
  function automatic int cv_predict_event(input midi_ev_t ev, output cv_frame_t [2:0] res);
    logic [3:0] cmd;
    logic [7:0] chan;
    int         hit;
    int         n;
    cmd  = ev.status[7:4];
    chan = {4'h0, ev.status[3:0]};
    hit  = -1;
    n    = 0;
    res  = '0;
    if (cmd == CMD_NOTE_ON && ev.d2 != 8'h00) begin
      for (int i = 0; i < SLOT_COUNT; i++)
        if (hit < 0 && vc_chan[i] == chan) hit = i;
      if (hit >= 0) begin
        vc_note[hit] = ev.d1;
        res = voice_words(hit, 1'b1, {ev.d2[6:0], 1'b0});
        n = 3;
      end
    end else if (cmd == CMD_NOTE_ON || (cmd == CMD_NOTE_OFF && !ev.sx)) begin
      for (int i = 0; i < SLOT_COUNT; i++)
        if (hit < 0 && vc_chan[i] == chan && vc_note[i] != NO_NOTE && vc_note[i] == ev.d1)
          hit = i;
      if (hit >= 0) begin
        vc_note[hit] = NO_NOTE;
        res = voice_words(hit, 1'b0, 8'h00);
        n = 3;
      end
    end else if (cmd == CMD_CTRL) begin
      for (int i = 0; i < SLOT_COUNT; i++)
        if (hit < 0 && cc_chan[i] == chan && cc_num[i] == ev.d1) hit = i;
      if (hit >= 0) begin
        res[0] = frm(KIND_DAC, LVL_CS[hit], level_word({ev.d2[6:0], 1'b0}, 1'b1), 2'd0, 1'b0,
                     1'b1);
        n = 1;
      end
    end else if (ev.sx && ev.d1 < SLOT_COUNT) begin
      case (ev.status)
        SX_VOICE_CHAN: vc_chan[ev.d1] = ev.d2;
        SX_CTRL_CHAN:  cc_chan[ev.d1] = ev.d2;
        SX_CTRL_NUM:   cc_num[ev.d1]  = ev.d2;
        default: ;
      endcase
    end
    return n;
  endfunction

  // Mostly well-formed traffic aimed at the current slot mapping, plus raw noise.
  function automatic midi_ev_t rand_event();
    midi_ev_t ev;
    int       r;
    int       s;
    r  = $urandom_range(99);
    s  = $urandom_range(SLOT_COUNT - 1);
    ev = '{status: 8'($urandom), d1: 8'($urandom), d2: 8'($urandom), sx: 1'b0};
    if (r < 30) begin
      ev.status = {CMD_NOTE_ON, vc_chan[s][3:0]};
      if ($urandom_range(3) != 0) ev.d1 = 8'(8'h3C + $urandom_range(3));
    end else if (r < 55) begin
      if (vc_note[s] != NO_NOTE) ev.d1 = vc_note[s];
      if ($urandom_range(1) == 0) begin
        ev.status = {CMD_NOTE_OFF, vc_chan[s][3:0]};
      end else begin
        ev.status = {CMD_NOTE_ON, vc_chan[s][3:0]};
        ev.d2 = 8'h00;
      end
    end else if (r < 75) begin
      ev.status = {CMD_CTRL, cc_chan[s][3:0]};
      ev.d1 = cc_num[s];
    end else if (r < 85) begin
      case ($urandom_range(2))
        0:       ev.status = SX_VOICE_CHAN;
        1:       ev.status = SX_CTRL_CHAN;
        default: ev.status = SX_CTRL_NUM;
      endcase
      ev.d1 = 8'($urandom_range(SLOT_COUNT));
      if ($urandom_range(7) != 0) ev.d2 = 8'($urandom_range(15));
      ev.sx = 1'b1;
    end else begin
      ev.sx = 1'($urandom);
    end
    return ev;
  endfunction

  task automatic drive_event(input midi_ev_t ev, input logic typed, input int tn,
                             input cv_frame_t [2:0] texp);
    cv_frame_t [2:0] pred;
    int              n;
    while ($urandom_range(99) < src_idle_pct) begin
      ev_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    ev_tvalid <= 1'b1;
    ev_tdata  <= {ev.d2, ev.d1, ev.status};
    ev_tuser  <= ev.sx;
    @(posedge clk_i);
    while (!ev_tready) @(posedge clk_i);
    n = cv_predict_event(ev, pred);
    if (typed) begin
      n    = tn;
      pred = texp;
    end
    for (int i = 0; i < n; i++) frames_due.push_back(pred[i]);
    n_events++;
  endtask

  task automatic drain_words();
    ev_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic void cmp_field(string nm, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, nm, want, got);
      n_errors++;
    end
  endfunction

  // Receiver: checks each accepted word, then picks the next tready.
  initial begin
    cv_frame_t got;
    cv_frame_t want;
    fr_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk_i);
      if (fr_tvalid && fr_tready) begin
        got = frm(fr_tuser[0], fr_tdata[7:0], fr_tdata[23:8], fr_tdata[25:24], fr_tdata[26],
                  fr_tlast);
        if (got.kind == KIND_GATE) n_gate_words++;
        else n_dac_words++;
        if (frames_due.size() == 0) begin
          $display("%0t: unexpected word: expected none, got %h", $time, got);
          n_errors++;
        end else begin
          want = frames_due.pop_front();
          cmp_field("frame_kind", 16'(want.kind), 16'(got.kind));
          cmp_field("select_mask", 16'(want.cs), 16'(got.cs));
          cmp_field("dac_word", want.word, got.word);
          cmp_field("gate_index", 16'(want.gidx), 16'(got.gidx));
          cmp_field("gate_level", 16'(want.glvl), 16'(got.glvl));
          cmp_field("last", 16'(want.last), 16'(got.last));
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 64;
      end
      if (hold_left > 0) begin
        hold_left--;
        fr_tready <= 1'b0;
      end else begin
        fr_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    cv_frame_t [2:0] none;
    cv_frame_t       g0;
    none      = '0;
    g0        = '0;
    rst_n     = 1'b0;
    ev_tvalid = 1'b0;
    ev_tdata  = '0;
    ev_tuser  = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      vc_chan[i] = 8'(i);
      vc_note[i] = NO_NOTE;
      cc_chan[i] = 8'h00;
      cc_num[i]  = 8'(i);
    end

    // Columns: status, first, second, sysex, typed, count, expected words.
    dir_tab.push_back(row(8'h90, 8'd60, 8'h7F, 1'b0, 1'b1, 2'd3,
      frm(KIND_GATE, 8'h00, 16'h0000, 2'd0, 1'b1, 1'b0),
      frm(KIND_DAC, 8'h10, 16'h3FE0, 2'd0, 1'b0, 1'b0),
      frm(KIND_DAC, 8'h80, 16'h3FFF, 2'd0, 1'b0, 1'b1)));
    dir_tab.push_back(row(8'h80, 8'd60, 8'h40, 1'b0, 1'b1, 2'd3,
      frm(KIND_GATE, 8'h00, 16'h0000, 2'd0, 1'b0, 1'b0),
      frm(KIND_DAC, 8'h10, 16'h3000, 2'd0, 1'b0, 1'b0),
      frm(KIND_DAC, 8'h80, 16'h3000, 2'd0, 1'b0, 1'b1)));
    dir_tab.push_back(row(8'h80, 8'd60, 8'h00, 1'b0, 1'b1, 2'd0, g0, g0, g0));
    dir_tab.push_back(row(8'h91, 8'h00, 8'h01, 1'b0, 1'b0, 2'd0, g0, g0, g0));
    dir_tab.push_back(row(8'h92, 8'h7F, 8'hFF, 1'b0, 1'b0, 2'd0, g0, g0, g0));
    dir_tab.push_back(row(8'h91, 8'h00, 8'h00, 1'b0, 1'b0, 2'd0, g0, g0, g0));
    dir_tab.push_back(row(8'h93, 8'h40, 8'h40, 1'b0, 1'b1, 2'd0, g0, g0, g0));
    dir_tab.push_back(row(8'h90, 8'hFF, 8'h10, 1'b0, 1'b0, 2'd0, g0, g0, g0));
    dir_tab.push_back(row(8'h80, 8'hFF, 8'h00, 1'b0, 1'b1, 2'd0, g0, g0, g0));
    dir_tab.push_back(row(8'hB0, 8'h00, 8'h7F, 1'b0, 1'b1, 2'd1,
      frm(KIND_DAC, 8'h10, 16'hBFE0, 2'd0, 1'b0, 1'b1), g0, g0));
    dir_tab.push_back(row(8'hB0, 8'h02, 8'h00, 1'b0, 1'b0, 2'd0, g0, g0, g0));
    dir_tab.push_back(row(8'hB5, 8'h00, 8'h33, 1'b0, 1'b1, 2'd0, g0, g0, g0));
    dir_tab.push_back(row(SX_VOICE_CHAN, 8'h02, 8'h09, 1'b1, 1'b1, 2'd0, g0, g0, g0));
    dir_tab.push_back(row(8'h99, 8'h3C, 8'h22, 1'b0, 1'b0, 2'd0, g0, g0, g0));
    dir_tab.push_back(row(SX_CTRL_CHAN, 8'h01, 8'h0F, 1'b1, 1'b1, 2'd0, g0, g0, g0));
    dir_tab.push_back(row(8'hBF, 8'h01, 8'h55, 1'b0, 1'b0, 2'd0, g0, g0, g0));
    dir_tab.push_back(row(SX_CTRL_NUM, 8'h00, 8'hFF, 1'b1, 1'b1, 2'd0, g0, g0, g0));
    dir_tab.push_back(row(8'hB0, 8'hFF, 8'h80, 1'b0, 1'b0, 2'd0, g0, g0, g0));
    dir_tab.push_back(row(SX_VOICE_CHAN, 8'h03, 8'h05, 1'b1, 1'b1, 2'd0, g0, g0, g0));
    dir_tab.push_back(row(SX_CTRL_NUM, 8'hFF, 8'h07, 1'b1, 1'b1, 2'd0, g0, g0, g0));
    dir_tab.push_back(row(8'h40, 8'h00, 8'h20, 1'b1, 1'b1, 2'd0, g0, g0, g0));
    dir_tab.push_back(row(8'h55, 8'h00, 8'h00, 1'b1, 1'b1, 2'd0, g0, g0, g0));
    dir_tab.push_back(row(SX_VOICE_CHAN, 8'h01, 8'hC8, 1'b1, 1'b1, 2'd0, g0, g0, g0));
    dir_tab.push_back(row(8'h98, 8'h10, 8'h10, 1'b0, 1'b1, 2'd0, g0, g0, g0));
    dir_tab.push_back(row(8'h89, 8'h3C, 8'h00, 1'b1, 1'b1, 2'd0, g0, g0, g0));
    dir_tab.push_back(row(8'h99, 8'h3C, 8'h00, 1'b1, 1'b0, 2'd0, g0, g0, g0));
    dir_tab.push_back(row(SX_VOICE_CHAN, 8'h01, 8'h01, 1'b1, 1'b1, 2'd0, g0, g0, g0));
    dir_tab.push_back(row(8'hF0, 8'hFF, 8'hFF, 1'b0, 1'b1, 2'd0, g0, g0, g0));

    src_idle_pct = 26;
    snk_idle_pct = 84;
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i])
      drive_event(dir_tab[i].ev, dir_tab[i].typed, dir_tab[i].n, dir_tab[i].exp);
    drain_words();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 26;
          snk_idle_pct = 84;
        end
        1: begin
          src_idle_pct = 84;
          snk_idle_pct = 26;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
          hold_req     = 1'b1;
        end
      endcase
      repeat (RAND_PER_PHASE) drive_event(rand_event(), 1'b0, 0, none);
      drain_words();
    end

    repeat (10) @(posedge clk_i);
    if (frames_due.size() != 0) begin
      $display("%0t: %0d expected words never arrived, expected %h, got none", $time,
               frames_due.size(), frames_due[0]);
      n_errors++;
    end
    $display("Sent %0d MIDI events (note on/off, control change, sysex remap, noise).",
             n_events);
    $display("Checked %0d gate words and %0d DAC words under three stall patterns.",
             n_gate_words, n_dac_words);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d words outstanding", $time, frames_due.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
